// File: rtl/core/twm_pkg.sv
// ----------------------------------------------------------------------------
// twm_pkg
// Shared widths, codes and record types of the watermark event merger.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int TIME_W  = 64;
  localparam int OP_W    = 2;
  localparam int SRC_IN_W = 3;
  localparam int KIND_W  = 2;
  localparam int CFG_W   = 4;

  localparam int NUM_SOURCES_DEF = 8;
  localparam int STORE_DEPTH_DEF = 32;

  localparam logic [CFG_W-1:0]  CFG_COUNT_RST = 4'd2;
  localparam logic [TIME_W-1:0] TIME_MAX      = 64'hffff_ffff_ffff_ffff;

  // Input operation codes
  localparam logic [OP_W-1:0] OP_EVENT   = 2'd0;
  localparam logic [OP_W-1:0] OP_END     = 2'd1;
  localparam logic [OP_W-1:0] OP_PROCESS = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = 2'd0;
  localparam logic [KIND_W-1:0] KIND_EVENT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SPAN   = 2'd2;

  // One stored event, as it sits in the event memory
  typedef struct packed {
    logic [TIME_W-1:0] ev_time;
    logic [TIME_W-1:0] ev_code;
    logic [TIME_W-1:0] ev_len;
  } entry_t;

  // One result item
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TIME_W-1:0] out_code;
    logic [TIME_W-1:0] out_time;
    logic [TIME_W-1:0] out_length;
    logic [TIME_W-1:0] span_start;
    logic [TIME_W-1:0] span_end;
    logic              overflow;
    logic              last;
  } res_t;

endpackage

// File: rtl/core/twm_if.sv
// ----------------------------------------------------------------------------
// twm channel interfaces
// Valid/ready channels for input items, result items and the config write.
// ----------------------------------------------------------------------------
interface twm_in_if;
  logic                         valid;
  logic                         ready;
  logic [twm_pkg::OP_W-1:0]     operation;
  logic [twm_pkg::SRC_IN_W-1:0] source;
  logic [twm_pkg::TIME_W-1:0]   event_code;
  logic [twm_pkg::TIME_W-1:0]   event_time;
  logic [twm_pkg::TIME_W-1:0]   event_length;
  logic [twm_pkg::TIME_W-1:0]   chunk_end;

  modport src (output valid, operation, source, event_code, event_time,
               event_length, chunk_end, input ready);
  modport snk (input valid, operation, source, event_code, event_time,
               event_length, chunk_end, output ready);
endinterface

interface twm_out_if;
  logic                       valid;
  logic                       ready;
  logic [twm_pkg::KIND_W-1:0] kind;
  logic [twm_pkg::TIME_W-1:0] out_code;
  logic [twm_pkg::TIME_W-1:0] out_time;
  logic [twm_pkg::TIME_W-1:0] out_length;
  logic [twm_pkg::TIME_W-1:0] span_start;
  logic [twm_pkg::TIME_W-1:0] span_end;
  logic                       overflow;
  logic                       last;

  modport src (output valid, kind, out_code, out_time, out_length, span_start,
               span_end, overflow, last, input ready);
  modport snk (input valid, kind, out_code, out_time, out_length, span_start,
               span_end, overflow, last, output ready);
endinterface

interface twm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [twm_pkg::CFG_W-1:0] data;

  modport src (output valid, data, input ready);
  modport snk (input valid, data, output ready);
endinterface

// File: rtl/core/twm_ram.sv
// ----------------------------------------------------------------------------
// twm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module twm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// File: rtl/core/timestamp_watermark_event_merger.sv
// ----------------------------------------------------------------------------
// timestamp_watermark_event_merger
// Merges timestamped events into one date-ordered stream released by watermark.
// ----------------------------------------------------------------------------
// Work: an end time or a dropped event is handled as it is taken; an event
//   makes a read/compare/write walk from the tail, moving up each stored
//   event dated later than it, then writes itself into the gap.
// A process item compares the active end times (one compare per cycle),
//   then sends any unsent header, the released events and the span (none if
//   the watermark is behind the last span end); a result stall can hold each.
// One item is in work at a time; a finished result may wait in the output
//   register while the next item is taken.
// Reset (synchronous, rst_n low): store empty, end times and span start zero,
//   flags clear, source count 2. The event RAM needs no clearing pass.
module timestamp_watermark_event_merger #(
  parameter int NUM_SOURCES = twm_pkg::NUM_SOURCES_DEF,
  parameter int STORE_DEPTH = twm_pkg::STORE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  twm_cfg_if.snk        cfg_ch,
  twm_in_if.snk         in_ch,
  twm_out_if.src        out_ch
);

  import twm_pkg::*;

  localparam int AW     = $clog2(STORE_DEPTH);
  localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
  localparam int SRC_W  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int CIDX_W = $clog2(NUM_SOURCES + 1);

  // Sequencer states
  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_MIN     = 3'd1;
  localparam logic [2:0] ST_HDR     = 3'd2;
  localparam logic [2:0] ST_REL_CHK = 3'd3;
  localparam logic [2:0] ST_REL_CMP = 3'd4;
  localparam logic [2:0] ST_SPAN    = 3'd5;
  localparam logic [2:0] ST_INS_CHK = 3'd6;
  localparam logic [2:0] ST_INS_CMP = 3'd7;

  // Map a position in sorted order onto a RAM address. The store is a ring
  // that starts at the head, so releasing from the front moves no data.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0]    head,
                                         input logic [CNT_W-1:0] pos);
    logic [AW:0] sum;
    sum = {1'b0, head} + (AW+1)'(pos);
    if (sum >= (AW+1)'(STORE_DEPTH)) begin
      sum = sum - (AW+1)'(STORE_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [AW-1:0]     head_r, head_nxt;
  logic [CNT_W-1:0]  k_r, k_nxt;
  logic [CIDX_W-1:0] sidx_r, sidx_nxt;
  logic [CIDX_W-1:0] active_r, active_nxt;
  logic [TIME_W-1:0] mark_r, mark_nxt;
  logic [TIME_W-1:0] prev_end_r, prev_end_nxt;
  logic              hdr_done_r, hdr_done_nxt;
  logic              ovf_r, ovf_nxt;
  logic [CFG_W-1:0]  cfg_count_r;
  logic [TIME_W-1:0] end_r [NUM_SOURCES];
  entry_t            new_r, new_nxt;

  logic              out_valid_r, out_valid_nxt;
  res_t              res_r, res_nxt;
  logic              out_free;

  logic              in_fire;
  logic              end_we;
  logic [SRC_W-1:0]  end_idx;
  logic              rel_emit;
  logic              ins_place;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [$bits(entry_t)-1:0] ram_rdata;
  entry_t            rd_ent;

  twm_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign rd_ent = entry_t'(ram_rdata);

  // Take one item at a time; the result register parts us from the sink.
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  // End-time write: out-of-range sources are dropped.
  assign end_idx = SRC_W'(in_ch.source);
  assign end_we  = in_fire && (in_ch.operation == OP_END) &&
                   (32'(in_ch.source) < NUM_SOURCES);

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    head_nxt      = head_r;
    k_nxt         = k_r;
    sidx_nxt      = sidx_r;
    active_nxt    = active_r;
    mark_nxt      = mark_r;
    prev_end_nxt  = prev_end_r;
    hdr_done_nxt  = hdr_done_r;
    ovf_nxt       = ovf_r;
    new_nxt       = new_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    res_nxt       = res_r;
    rel_emit      = 1'b0;
    ins_place     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = phys(head_r, k_r);
    ram_wdata     = new_r;
    ram_re        = 1'b0;
    ram_raddr     = head_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          unique case (in_ch.operation)
            OP_EVENT: begin
              if (32'(cnt_r) >= STORE_DEPTH) begin
                // Full: drop the event and flag it for good
                ovf_nxt = 1'b1;
              end else begin
                new_nxt.ev_time = in_ch.event_time;
                new_nxt.ev_code = in_ch.event_code;
                new_nxt.ev_len  = in_ch.event_length;
                k_nxt           = cnt_r;
                state_nxt       = ST_INS_CHK;
              end
            end
            OP_PROCESS: begin
              sidx_nxt   = '0;
              mark_nxt   = TIME_MAX;
              active_nxt = (32'(cfg_count_r) < NUM_SOURCES) ?
                           CIDX_W'(cfg_count_r) : CIDX_W'(NUM_SOURCES);
              state_nxt  = ST_MIN;
            end
            default: begin
              // End times are written below; unused codes do nothing.
            end
          endcase
        end
      end

      // Watermark: one source per cycle into the running minimum
      ST_MIN: begin
        if (sidx_r < active_r) begin
          if (end_r[sidx_r[SRC_W-1:0]] < mark_r) begin
            mark_nxt = end_r[sidx_r[SRC_W-1:0]];
          end
          sidx_nxt = sidx_r + 1'b1;
        end else begin
          state_nxt = ST_HDR;
        end
      end

      // Header once, ahead of everything; it closes the item when the
      // watermark falls behind the last span end.
      ST_HDR: begin
        if (!hdr_done_r) begin
          if (out_free) begin
            res_nxt            = '0;
            res_nxt.kind       = KIND_HEADER;
            res_nxt.span_start = prev_end_r;
            res_nxt.span_end   = prev_end_r;
            res_nxt.overflow   = ovf_r;
            res_nxt.last       = (mark_r < prev_end_r);
            out_valid_nxt      = 1'b1;
            hdr_done_nxt       = 1'b1;
            state_nxt          = (mark_r >= prev_end_r) ? ST_REL_CHK : ST_IDLE;
          end
        end else begin
          state_nxt = (mark_r >= prev_end_r) ? ST_REL_CHK : ST_IDLE;
        end
      end

      // Release: read the oldest entry at the head of the ring
      ST_REL_CHK: begin
        if (cnt_r == '0) begin
          state_nxt = ST_SPAN;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = head_r;
          state_nxt = ST_REL_CMP;
        end
      end

      ST_REL_CMP: begin
        if (rd_ent.ev_time < mark_r) begin
          // Hold the read data until the result slot frees up
          if (out_free) begin
            res_nxt            = '0;
            res_nxt.kind       = KIND_EVENT;
            res_nxt.out_code   = rd_ent.ev_code;
            res_nxt.out_time   = rd_ent.ev_time;
            res_nxt.out_length = rd_ent.ev_len;
            res_nxt.overflow   = ovf_r;
            out_valid_nxt      = 1'b1;
            rel_emit           = 1'b1;
            head_nxt           = phys(head_r, CNT_W'(1));
            cnt_nxt            = cnt_r - 1'b1;
            state_nxt          = ST_REL_CHK;
          end
        end else begin
          state_nxt = ST_SPAN;
        end
      end

      ST_SPAN: begin
        if (out_free) begin
          res_nxt            = '0;
          res_nxt.kind       = KIND_SPAN;
          res_nxt.span_start = prev_end_r;
          res_nxt.span_end   = mark_r;
          res_nxt.overflow   = ovf_r;
          res_nxt.last       = 1'b1;
          out_valid_nxt      = 1'b1;
          prev_end_nxt       = mark_r;
          state_nxt          = ST_IDLE;
        end
      end

      // Insertion: walk from the tail, moving later-dated entries up by one
      ST_INS_CHK: begin
        if (k_r == '0) begin
          ram_we    = 1'b1;
          ram_waddr = phys(head_r, k_r);
          ram_wdata = new_r;
          cnt_nxt   = cnt_r + 1'b1;
          ins_place = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = phys(head_r, CNT_W'(k_r - 1'b1));
          state_nxt = ST_INS_CMP;
        end
      end

      ST_INS_CMP: begin
        ram_we    = 1'b1;
        ram_waddr = phys(head_r, k_r);
        if (rd_ent.ev_time > new_r.ev_time) begin
          // Equal dates stay put, so arrival order is kept
          ram_wdata = rd_ent;
          k_nxt     = k_r - 1'b1;
          state_nxt = ST_INS_CHK;
        end else begin
          ram_wdata = new_r;
          cnt_nxt   = cnt_r + 1'b1;
          ins_place = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      head_r      <= '0;
      k_r         <= '0;
      sidx_r      <= '0;
      active_r    <= '0;
      mark_r      <= '0;
      prev_end_r  <= '0;
      hdr_done_r  <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
      cfg_count_r <= CFG_COUNT_RST;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      head_r      <= head_nxt;
      k_r         <= k_nxt;
      sidx_r      <= sidx_nxt;
      active_r    <= active_nxt;
      mark_r      <= mark_nxt;
      prev_end_r  <= prev_end_nxt;
      hdr_done_r  <= hdr_done_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        cfg_count_r <= cfg_ch.data;
      end
    end
  end

  // Per-source end times
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SOURCES; i++) begin
        end_r[i] <= '0;
      end
    end else if (end_we) begin
      end_r[end_idx] <= in_ch.chunk_end;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    new_r <= new_nxt;
    res_r <= res_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = res_r.kind;
  assign out_ch.out_code   = res_r.out_code;
  assign out_ch.out_time   = res_r.out_time;
  assign out_ch.out_length = res_r.out_length;
  assign out_ch.span_start = res_r.span_start;
  assign out_ch.span_end   = res_r.span_end;
  assign out_ch.overflow   = res_r.overflow;
  assign out_ch.last       = res_r.last;

  // Fill level never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= STORE_DEPTH)
    else $error("event store count beyond depth");

  // A released event is dated before the watermark of its process item
  a_rel_before_mark: assert property (@(posedge clk) disable iff (!rst_n)
    rel_emit |=> (res_r.out_time < mark_r))
    else $error("released event not before watermark");

  // Placing an event grows the store by exactly one
  a_ins_grow: assert property (@(posedge clk) disable iff (!rst_n)
    ins_place |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("insertion did not grow the store by one");

  // Span end never moves backward
  a_prev_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (prev_end_r >= $past(prev_end_r)))
    else $error("span end moved backward");

endmodule
